>>> design/hmc_pkg.sv
// Shared types, constants and reciprocal tables for the HSV mask centroid block.
package hmc_pkg;

	localparam int MAX_FRAME_COLS = 2048;
	localparam int MAX_FRAME_ROWS = 2048;
	localparam int POS_W  = 11;
	localparam int SUM_W  = 33;
	localparam int CNT_W  = 23;
	localparam int CRD_W  = 12;
	localparam int FIX    = 12;
	localparam int SAT_TW = 20;
	localparam int HUE_TW = 17;
	localparam int STEP_W = 6;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_FRAME_COLS = 3'd0,
		REG_FRAME_ROWS = 3'd1,
		REG_ROI_LEFT   = 3'd2,
		REG_ROI_TOP    = 3'd3,
		REG_ROI_WIDTH  = 3'd4,
		REG_ROI_HEIGHT = 3'd5,
		REG_LOWER_HSV  = 3'd6,
		REG_UPPER_HSV  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        frame_cols;
		logic [11:0]        frame_rows;
		logic signed [11:0] roi_left;
		logic signed [11:0] roi_top;
		logic [11:0]        roi_width;
		logic [11:0]        roi_height;
		logic [23:0]        lower_hsv;
		logic [23:0]        upper_hsv;
	} cfg_t;

	// One finished frame handed from the accumulator to the divider
	typedef struct packed {
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
		logic [CNT_W-1:0] count;
		logic [POS_W-1:0] org_x;
		logic [POS_W-1:0] org_y;
	} frame_res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef logic [SAT_TW-1:0] sat_tab_t [256];
	typedef logic [HUE_TW-1:0] hue_tab_t [256];

	// Bitwise long division, elaboration only
	function automatic logic [23:0] long_div(logic [23:0] n, logic [23:0] d);
		logic [24:0] r;
		logic [23:0] q;
		r = '0;
		q = '0;
		for (int k = 23; k >= 0; k--) begin
			r = {r[23:0], n[k]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	// Rounded (255 << 12) / v
	function automatic sat_tab_t build_sat();
		sat_tab_t t;
		logic [23:0] q;
		for (int i = 0; i < 256; i++) begin
			q = long_div(24'((255 << FIX) * 2 + i), 24'(2 * i));
			t[i] = (i == 0) ? '0 : q[SAT_TW-1:0];
		end
		return t;
	endfunction

	// Rounded (30 << 12) / diff
	function automatic hue_tab_t build_hue();
		hue_tab_t t;
		logic [23:0] q;
		for (int i = 0; i < 256; i++) begin
			q = long_div(24'((30 << FIX) * 2 + i), 24'(2 * i));
			t[i] = (i == 0) ? '0 : q[HUE_TW-1:0];
		end
		return t;
	endfunction

	localparam sat_tab_t SAT_TAB = build_sat();
	localparam hue_tab_t HUE_TAB = build_hue();

endpackage

>>> design/hmc_front.sv
// Front end: pixel intake, region test, HSV threshold and per-frame accumulation.
module hmc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hmc_pkg::cfg_t         cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,  // pix_blue, pix_green, pix_red
	input  logic                  s_tuser,  // start_of_frame
	input  logic                  s_tlast,  // end_of_frame
	output logic                  push,
	output hmc_pkg::frame_res_t   push_data,
	input  logic                  fifo_full
);
	import hmc_pkg::*;

	logic [11:0] fc, fr;
	logic [POS_W-1:0] ox, oy;
	logic [12:0] endx, endy, ex, ey;
	logic [POS_W-1:0] col_q, row_q, col_eff, row_eff;
	logic [11:0] ncol;
	logic wrap, in_roi, adv, xfer;
	logic [7:0] pb, pg, pr, mx, mn, diff;
	logic signed [11:0] hr;

	logic             vld_s1, roi_s1, sof_s1, eof_s1;
	logic [7:0]       v_s1, diff_s1;
	logic signed [11:0] hr_s1;
	logic [POS_W-1:0] lx_s1, ly_s1;

	logic             vld_s2, roi_s2, sof_s2, eof_s2;
	logic [7:0]       v_s2;
	logic [27:0]      sprod_s2;
	logic signed [29:0] hprod_s2;
	logic [POS_W-1:0] lx_s2, ly_s2;

	logic [27:0] sat_r;
	logic [8:0]  sat;
	logic signed [29:0] ht, hs, hadj;
	logic [8:0]  hue;
	logic match, add;
	logic [SUM_W-1:0] sumx_q, sumy_q, nx, ny;
	logic [CNT_W-1:0] cnt_q, nc;

	// Frame size and region clamp
	always_comb begin
		fc = (cfg.frame_cols == '0) ? 12'd1 :
		     (cfg.frame_cols > 12'(MAX_FRAME_COLS)) ? 12'(MAX_FRAME_COLS) : cfg.frame_cols;
		fr = (cfg.frame_rows == '0) ? 12'd1 :
		     (cfg.frame_rows > 12'(MAX_FRAME_ROWS)) ? 12'(MAX_FRAME_ROWS) : cfg.frame_rows;
		ox = cfg.roi_left[11] ? '0 : cfg.roi_left[10:0];
		oy = cfg.roi_top[11] ? '0 : cfg.roi_top[10:0];
		endx = {2'b0, ox} + {1'b0, cfg.roi_width};
		endy = {2'b0, oy} + {1'b0, cfg.roi_height};
		ex = (endx >= {1'b0, fc}) ? ({1'b0, fc} - 13'd1) : endx;
		ey = (endy >= {1'b0, fr}) ? ({1'b0, fr} - 13'd1) : endy;
	end

	// Raster position of the incoming pixel
	always_comb begin
		col_eff = s_tuser ? '0 : col_q;
		row_eff = s_tuser ? '0 : row_q;
		ncol = {1'b0, col_eff} + 12'd1;
		wrap = (ncol >= fc) || ncol[11];
		in_roi = (col_eff >= ox) && ({2'b0, col_eff} < ex) &&
		         (row_eff >= oy) && ({2'b0, row_eff} < ey);
	end

	// Stall only when a finished frame cannot enter the queue
	assign adv = !(vld_s2 && eof_s2 && fifo_full);
	assign s_tready = adv;
	assign xfer = s_tvalid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (xfer) begin
			if (s_tlast) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_eff + 11'd1;
			end else begin
				col_q <= ncol[10:0];
				row_q <= row_eff;
			end
		end
	end

	// Max, min and hue numerator
	always_comb begin
		pb = s_tdata[7:0];
		pg = s_tdata[15:8];
		pr = s_tdata[23:16];
		mx = pb;
		if (pg > mx) mx = pg;
		if (pr > mx) mx = pr;
		mn = pb;
		if (pg < mn) mn = pg;
		if (pr < mn) mn = pr;
		diff = mx - mn;
		priority if (diff == '0) begin
			hr = '0;
		end else if (mx == pr) begin
			hr = $signed({4'b0, pg}) - $signed({4'b0, pb});
		end else if (mx == pg) begin
			hr = $signed({4'b0, pb}) - $signed({4'b0, pr}) + $signed({3'b0, diff, 1'b0});
		end else begin
			hr = $signed({4'b0, pr}) - $signed({4'b0, pg}) + $signed({2'b0, diff, 2'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1 and 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1     <= mx;
			diff_s1  <= diff;
			hr_s1    <= hr;
			roi_s1   <= in_roi;
			lx_s1    <= col_eff - ox;
			ly_s1    <= row_eff - oy;
			sof_s1   <= s_tuser;
			eof_s1   <= s_tlast;
			v_s2     <= v_s1;
			sprod_s2 <= {20'b0, diff_s1} * {8'b0, SAT_TAB[v_s1]};
			hprod_s2 <= 30'(hr_s1) * $signed({13'b0, HUE_TAB[diff_s1]});
			roi_s2   <= roi_s1;
			lx_s2    <= lx_s1;
			ly_s2    <= ly_s1;
			sof_s2   <= sof_s1;
			eof_s2   <= eof_s1;
		end
	end

	// Rounding, hue wrap and threshold test
	always_comb begin
		sat_r = sprod_s2 + 28'd2048;
		sat   = sat_r[20:12];
		ht    = hprod_s2 + 30'sd2048;
		hs    = ht >>> FIX;
		hadj  = (hs < 0) ? (hs + 30'sd180) : hs;
		hue   = hadj[8:0];
		match = (hue >= {1'b0, cfg.lower_hsv[23:16]}) && (hue <= {1'b0, cfg.upper_hsv[23:16]}) &&
		        (sat >= {1'b0, cfg.lower_hsv[15:8]}) && (sat <= {1'b0, cfg.upper_hsv[15:8]}) &&
		        (v_s2 >= cfg.lower_hsv[7:0]) && (v_s2 <= cfg.upper_hsv[7:0]);
		add = roi_s2 && match;
		nx = (sof_s2 ? '0 : sumx_q) + (add ? {22'b0, lx_s2} : '0);
		ny = (sof_s2 ? '0 : sumy_q) + (add ? {22'b0, ly_s2} : '0);
		nc = (sof_s2 ? '0 : cnt_q) + (add ? 23'd1 : 23'd0);
	end

	// Frame accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sumx_q <= '0;
			sumy_q <= '0;
			cnt_q  <= '0;
		end else if (adv && vld_s2) begin
			if (eof_s2) begin
				sumx_q <= '0;
				sumy_q <= '0;
				cnt_q  <= '0;
			end else begin
				sumx_q <= nx;
				sumy_q <= ny;
				cnt_q  <= nc;
			end
		end
	end

	assign push = adv && vld_s2 && eof_s2;
	assign push_data = '{sum_x: nx, sum_y: ny, count: nc, org_x: ox, org_y: oy};

endmodule

>>> design/hmc_fifo.sv
// Two-entry queue of finished frame totals between accumulator and divider.
module hmc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hmc_pkg::frame_res_t wr_data,
	output logic                full,
	input  logic                pop,
	output hmc_pkg::frame_res_t rd_data,
	output logic                empty
);
	import hmc_pkg::*;

	frame_res_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

>>> design/hmc_back.sv
// Back end: iterative centroid divide and result register.
module hmc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  hmc_pkg::frame_res_t rd_data,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,  // head_x, head_y
	output logic                m_tuser   // found
);
	import hmc_pkg::*;

	back_state_t state_q, state_d;
	logic [SUM_W-1:0]  nx_q, ny_q, nx_d, ny_d;
	logic [CNT_W:0]    rx_q, ry_q, rx_d, ry_d, tx, ty;
	logic [CNT_W-1:0]  den_q;
	logic [POS_W-1:0]  x0_q, y0_q;
	logic [STEP_W-1:0] step_q;
	logic              last, gx, gy, ok;
	logic [CRD_W-1:0]  hx_q, hy_q;
	logic              found_q;

	// One restoring step per cycle on both sums
	always_comb begin
		tx = {rx_q[CNT_W-1:0], nx_q[SUM_W-1]};
		ty = {ry_q[CNT_W-1:0], ny_q[SUM_W-1]};
		gx = tx >= {1'b0, den_q};
		gy = ty >= {1'b0, den_q};
		rx_d = gx ? (tx - {1'b0, den_q}) : tx;
		ry_d = gy ? (ty - {1'b0, den_q}) : ty;
		nx_d = {nx_q[SUM_W-2:0], gx};
		ny_d = {ny_q[SUM_W-2:0], gy};
		last = (step_q == STEP_W'(SUM_W - 1));
		ok = (den_q != '0) && (nx_d != '0) && (ny_d != '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!empty) state_d = BK_DIV;
			BK_DIV:  if (last) state_d = BK_DONE;
			BK_DONE: if (m_tready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop      = (state_q == BK_IDLE) && !empty;
		m_tvalid = (state_q == BK_DONE);
		m_tdata  = {hy_q, hx_q};
		m_tuser  = found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) step_q <= '0;
			else if (state_q == BK_DIV) step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			nx_q  <= rd_data.sum_x;
			ny_q  <= rd_data.sum_y;
			den_q <= rd_data.count;
			x0_q  <= rd_data.org_x;
			y0_q  <= rd_data.org_y;
			rx_q  <= '0;
			ry_q  <= '0;
		end else if (state_q == BK_DIV) begin
			nx_q <= nx_d;
			ny_q <= ny_d;
			rx_q <= rx_d;
			ry_q <= ry_d;
			if (last) begin
				found_q <= ok;
				hx_q <= ok ? (nx_d[CRD_W-1:0] + {1'b0, x0_q}) : '1;
				hy_q <= ok ? (ny_d[CRD_W-1:0] + {1'b0, y0_q}) : '1;
			end
		end
	end

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '1))
		else $error("not-found result without -1 coordinates");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (step_q < STEP_W'(SUM_W)))
		else $error("divide step past quotient width");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV && last) |=> m_tvalid)
		else $error("result missing after last divide step");

endmodule

>>> design/hsv_mask_centroid_in_roi_core.sv
// Top level: configuration registers, front end, frame queue and divider.
//
//  channel | role   | handshake          | payload
//  s_*     | pixels | s_tvalid/s_tready  | tdata blue,green,red; tuser sof; tlast eof
//  m_*     | result | m_tvalid/m_tready  | tdata head_x,head_y; tuser found
//  cfg_*   | config | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Pixels enter at one per clock through the pipelined front end; the
// back end computes the centroid with a 33-step shift-subtract divider.
// The two-entry queue absorbs frame totals; s_tready drops only when it is
// full and an end-of-frame pixel waits. Reset restores register defaults.
module hsv_mask_centroid_in_roi_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pix_blue, pix_green, pix_red
	input  logic        s_tuser,   // start_of_frame
	input  logic        s_tlast,   // end_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // head_x, head_y
	output logic        m_tuser,   // found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import hmc_pkg::*;

	cfg_t       cfg_q;
	logic       push, full, pop, empty;
	frame_res_t wr_data, rd_data;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_cols <= 12'd640;
			cfg_q.frame_rows <= 12'd480;
			cfg_q.roi_left   <= '0;
			cfg_q.roi_top    <= '0;
			cfg_q.roi_width  <= '0;
			cfg_q.roi_height <= '0;
			cfg_q.lower_hsv  <= 24'h055050;
			cfg_q.upper_hsv  <= 24'h19AAC8;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_COLS: cfg_q.frame_cols <= cfg_data[11:0];
				REG_FRAME_ROWS: cfg_q.frame_rows <= cfg_data[11:0];
				REG_ROI_LEFT:   cfg_q.roi_left   <= cfg_data[11:0];
				REG_ROI_TOP:    cfg_q.roi_top    <= cfg_data[11:0];
				REG_ROI_WIDTH:  cfg_q.roi_width  <= cfg_data[11:0];
				REG_ROI_HEIGHT: cfg_q.roi_height <= cfg_data[11:0];
				REG_LOWER_HSV:  cfg_q.lower_hsv  <= cfg_data;
				REG_UPPER_HSV:  cfg_q.upper_hsv  <= cfg_data;
			endcase
		end
	end

	hmc_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.push(push), .push_data(wr_data), .fifo_full(full)
	);

	hmc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_data(wr_data), .full(full),
		.pop(pop), .rd_data(rd_data), .empty(empty)
	);

	hmc_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .rd_data(rd_data), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the HSV mask centroid core: random frames, regions and bounds.
`timescale 1ns / 100ps

module tb_top;
	import hmc_pkg::*;

	// Expected centroid of one frame
	typedef struct {
		logic signed [11:0] head_x;
		logic signed [11:0] head_y;
		logic               found;
	} centroid_t;

	// Tracks the frame state of the core and predicts each frame's centroid
	class centroid_scoreboard;
		logic [11:0] frame_cols, frame_rows, roi_left, roi_top, roi_width, roi_height;
		logic [23:0] lower_hsv, upper_hsv;
		logic [10:0] col_pos, row_pos;
		logic [32:0] sum_x, sum_y;
		logic [22:0] hit_count;
		centroid_t   centroid_q[$];
		int          errors, frames, pixels, hits, found_cnt;

		function void reset_state();
			frame_cols = 12'd640;
			frame_rows = 12'd480;
			roi_left   = '0;
			roi_top    = '0;
			roi_width  = '0;
			roi_height = '0;
			lower_hsv  = 24'h055050;
			upper_hsv  = 24'h19AAC8;
			clear_frame();
		endfunction

		function void clear_frame();
			col_pos   = '0;
			row_pos   = '0;
			sum_x     = '0;
			sum_y     = '0;
			hit_count = '0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [23:0] data);
			case (idx)
				REG_FRAME_COLS: frame_cols = data[11:0];
				REG_FRAME_ROWS: frame_rows = data[11:0];
				REG_ROI_LEFT:   roi_left   = data[11:0];
				REG_ROI_TOP:    roi_top    = data[11:0];
				REG_ROI_WIDTH:  roi_width  = data[11:0];
				REG_ROI_HEIGHT: roi_height = data[11:0];
				REG_LOWER_HSV:  lower_hsv  = data;
				REG_UPPER_HSV:  upper_hsv  = data;
				default: ;
			endcase
		endfunction

		function int clamp_extent(logic [11:0] v, int maxv);
			int s;
			s = int'(v);
			if (s < 1) s = 1;
			if (s > maxv) s = maxv;
			return s;
		endfunction

		// Region origin goes to zero when negative; size stops short of the last index
		function void clamp_axis(logic [11:0] start, logic [11:0] size, int extent,
				output int org, output int len);
			org = int'($signed(start));
			len = int'(size);
			if (org < 0) org = 0;
			if (org + len >= extent) len = extent - 1 - org;
		endfunction

		function longint round_div(longint num, longint den);
			return (2 * num + den) / (2 * den);
		endfunction

		function bit hsv_in_range(logic [7:0] b, logic [7:0] g, logic [7:0] r);
			longint vmax, vmin, diff, sat, hue, t;
			vmax = longint'(b); vmin = longint'(b); sat = 0; hue = 0;
			if (g > vmax) vmax = longint'(g);
			if (r > vmax) vmax = longint'(r);
			if (g < vmin) vmin = longint'(g);
			if (r < vmin) vmin = longint'(r);
			diff = vmax - vmin;
			if (vmax != 0)
				sat = (diff * round_div(255 << 12, vmax) + 2048) >> 12;
			if (diff != 0) begin
				if (vmax == r) hue = longint'(g) - longint'(b);
				else if (vmax == g) hue = longint'(b) - longint'(r) + 2 * diff;
				else hue = longint'(r) - longint'(g) + 4 * diff;
				t = hue * round_div(30 << 12, diff) + 2048;
				t = t >>> 12;
				if (t < 0) t += 180;
				hue = t;
			end
			return hue >= lower_hsv[23:16] && hue <= upper_hsv[23:16] &&
				sat >= lower_hsv[15:8] && sat <= upper_hsv[15:8] &&
				vmax >= lower_hsv[7:0] && vmax <= upper_hsv[7:0];
		endfunction

		// One accepted pixel transfer
		function void note_pixel(logic [23:0] rgb, logic sof, logic eof);
			int fc, fr, x0, y0, w, h, col, row;
			logic [11:0] ncol;
			logic [32:0] cx, cy;
			centroid_t c;
			fc = clamp_extent(frame_cols, MAX_FRAME_COLS);
			fr = clamp_extent(frame_rows, MAX_FRAME_ROWS);
			pixels++;
			if (sof) clear_frame();
			clamp_axis(roi_left, roi_width, fc, x0, w);
			clamp_axis(roi_top, roi_height, fr, y0, h);
			col = int'(col_pos);
			row = int'(row_pos);
			if (w > 0 && h > 0 && col >= x0 && col < x0 + w && row >= y0 && row < y0 + h &&
					hsv_in_range(rgb[7:0], rgb[15:8], rgb[23:16])) begin
				sum_x = sum_x + 33'(col - x0);
				sum_y = sum_y + 33'(row - y0);
				hit_count = hit_count + 1'b1;
				hits++;
			end
			ncol = 12'(col_pos) + 12'd1;
			if (int'(ncol) >= fc || ncol > 12'd2047) begin
				col_pos = '0;
				row_pos = row_pos + 1'b1;
			end else begin
				col_pos = ncol[10:0];
			end
			if (!eof) return;
			c.found  = 1'b0;
			c.head_x = -12'sd1;
			c.head_y = -12'sd1;
			if (hit_count != 0) begin
				cx = sum_x / 33'(hit_count);
				cy = sum_y / 33'(hit_count);
				if (cx != 0 && cy != 0) begin
					c.found  = 1'b1;
					c.head_x = 12'(cx + 33'(x0));
					c.head_y = 12'(cy + 33'(y0));
				end
			end
			centroid_q.push_back(c);
			frames++;
			if (c.found) found_cnt++;
			clear_frame();
		endfunction

		function void check_centroid(logic [23:0] data, logic found);
			centroid_t c;
			if (centroid_q.size() == 0) begin
				$error("unexpected result transfer: head_x=%0d head_y=%0d found=%0b",
					$signed(data[11:0]), $signed(data[23:12]), found);
				errors++;
				return;
			end
			c = centroid_q.pop_front();
			if (data[11:0] !== c.head_x) begin
				$error("head_x mismatch: expected %0d actual %0d", c.head_x, $signed(data[11:0]));
				errors++;
			end
			if (data[23:12] !== c.head_y) begin
				$error("head_y mismatch: expected %0d actual %0d", c.head_y, $signed(data[23:12]));
				errors++;
			end
			if (found !== c.found) begin
				$error("found mismatch: expected %0b actual %0b", c.found, found);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // pix_blue, pix_green, pix_red
	logic        s_tuser;   // start_of_frame
	logic        s_tlast;   // end_of_frame
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // head_x, head_y
	logic        m_tuser;   // found
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	centroid_scoreboard sb;
	int burst_left;
	int ready_pct;
	int cycles;
	int phases;

	hsv_mask_centroid_in_roi_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watch every transfer and feed the scoreboard
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_pixel(s_tdata, s_tuser, s_tlast);
		if (arst_n && m_tvalid && m_tready) sb.check_centroid(m_tdata, m_tuser);
		if (arst_n && cfg_valid && cfg_ready) sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
	end

	// Receiver stalls at a per-phase rate
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 99) < ready_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("hsv_mask_centroid_in_roi_core test failed");
			$finish;
		end
	end

	task automatic write_cfg(reg_idx_t idx, logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One pixel transfer, then maybe a gap between bursts
	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic sof, logic eof);
		s_tvalid <= 1'b1;
		s_tdata  <= {r, g, b};
		s_tuser  <= sof;
		s_tlast  <= eof;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// Drain all results and let the divider settle before touching registers
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		// let the monitor see the last pixel transfer
		@(posedge clk);
		while (sb.centroid_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_all(logic [11:0] fc, logic [11:0] fr, logic [11:0] x0,
			logic [11:0] y0, logic [11:0] w, logic [11:0] h, logic [23:0] lo, logic [23:0] hi);
		write_cfg(REG_FRAME_COLS, 24'(fc));
		write_cfg(REG_FRAME_ROWS, 24'(fr));
		write_cfg(REG_ROI_LEFT, 24'(x0));
		write_cfg(REG_ROI_TOP, 24'(y0));
		write_cfg(REG_ROI_WIDTH, 24'(w));
		write_cfg(REG_ROI_HEIGHT, 24'(h));
		write_cfg(REG_LOWER_HSV, lo);
		write_cfg(REG_UPPER_HSV, hi);
	endtask

	task automatic send_frame(int npix, bit with_sof);
		logic [7:0] b, g, r;
		for (int i = 0; i < npix; i++) begin
			b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
			// occasionally force saturated or gray pixels
			case ($urandom_range(0, 7))
				0: begin b = 0; g = 0; r = 0; end
				1: begin g = b; r = b; end
				2: begin b = 8'hFF; g = 0; end
				default: ;
			endcase
			send_pixel(b, g, r, (i == 0 && with_sof) || ($urandom_range(0, 199) == 0),
				i == npix - 1);
		end
	endtask

	initial begin
		logic [11:0] fc, fr, x0, y0, w, h;
		logic [23:0] lo, hi;
		int npix;
		sb = new();
		sb.reset_state();
		cycles     = 0;
		burst_left = 0;
		ready_pct  = 100;
		phases     = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		s_tlast    = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_FRAME_COLS;
		cfg_data   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: empty region, nothing can match
		send_pixel(8'h00, 8'h80, 8'hFF, 1'b1, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
		wait_idle();

		// 4x4 frame, region clipped to 3x3, bounds wide open
		set_all(12'd4, 12'd4, 12'd0, 12'd0, 12'd4, 12'd4, 24'h000000, 24'hFFFFFF);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
		send_pixel(8'h00, 8'h00, 8'hFF, 1'b0, 1'b0);
		send_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_pixel(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
		send_pixel(8'h01, 8'hFE, 8'h80, 1'b0, 1'b0);
		send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
		send_pixel(8'h55, 8'hAA, 8'h55, 1'b0, 1'b1);
		// Frame with no start flag, only column 0 in region: zero local centroid
		send_pixel(8'h10, 8'h20, 8'h30, 1'b0, 1'b1);
		wait_idle();

		// Negative origin, zero and oversized frame sizes, narrow hue window
		set_all(12'd0, 12'hFFF, 12'h800, 12'hFFE, 12'd3, 12'hFFF, 24'h050000, 24'h19FFFF);
		for (int i = 0; i < 6; i++) send_pixel(8'h00, 8'h80, 8'hFF, 1'b0, i == 5);
		wait_idle();

		// Origin past the frame gives an empty region
		set_all(12'd8, 12'd8, 12'h7FF, 12'h7FF, 12'd5, 12'd5, 24'h000000, 24'hFFFFFF);
		for (int i = 0; i < 4; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0, i == 3);
		wait_idle();

		// Random phases of register settings and frames
		while (sb.pixels < 1300) begin
			phases++;
			ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(15, 95);
			fc = 12'($urandom_range(1, 12));
			fr = 12'($urandom_range(1, 10));
			if ($urandom_range(0, 9) == 0) fc = ($urandom_range(0, 1)) ? 12'd0 : 12'hFFF;
			if ($urandom_range(0, 9) == 0) fr = ($urandom_range(0, 1)) ? 12'd0 : 12'd2048;
			x0 = 12'($signed($urandom_range(0, 16)) - 3);
			y0 = 12'($signed($urandom_range(0, 14)) - 3);
			w  = 12'($urandom_range(0, 14));
			h  = 12'($urandom_range(0, 12));
			if ($urandom_range(0, 12) == 0) x0 = ($urandom_range(0, 1)) ? 12'h800 : 12'h7FF;
			if ($urandom_range(0, 12) == 0) y0 = ($urandom_range(0, 1)) ? 12'h800 : 12'h7FF;
			if ($urandom_range(0, 10) == 0) w = 12'hFFF;
			if ($urandom_range(0, 10) == 0) h = 12'hFFF;
			case ($urandom_range(0, 3))
				0: begin lo = 24'h000000; hi = 24'hFFFFFF; end
				1: begin lo = 24'($urandom); hi = 24'($urandom); end
				default: begin
					lo = {8'($urandom_range(0, 120)), 8'($urandom_range(0, 120)),
						8'($urandom_range(0, 120))};
					hi = {8'($urandom_range(60, 255)), 8'($urandom_range(120, 255)),
						8'($urandom_range(120, 255))};
				end
			endcase
			set_all(fc, fr, x0, y0, w, h, lo, hi);
			repeat ($urandom_range(1, 4)) begin
				npix = (fc >= 1 && fc <= 12 && fr >= 1 && fr <= 10) ?
					int'(fc) * int'(fr) : $urandom_range(1, 40);
				if ($urandom_range(0, 5) == 0) npix = $urandom_range(1, npix);
				send_frame(npix, $urandom_range(0, 9) != 0);
			end
			wait_idle();
		end

		if (sb.centroid_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.centroid_q.size());
			sb.errors++;
		end
		$display("Covered %0d pixels in %0d frames over %0d register settings;",
			sb.pixels, sb.frames, phases + 4);
		$display("%0d pixels matched, %0d frames reported a centroid.", sb.hits, sb.found_cnt);
		if (sb.errors == 0) begin
			$display("hsv_mask_centroid_in_roi_core test passed");
		end else begin
			$display("hsv_mask_centroid_in_roi_core test failed");
		end
		$finish;
	end

endmodule
